// ===== src/block_buffer_cache_lru_macros.svh =====
// ---------------------------------------------------------------------------
// Block buffer cache assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bbc_pkg.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache package
// Command and status codes, controller states and the entry record.
// ---------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_UNDER = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_UPD  = 2'd2
    } t_state;

    // One directory entry
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [31:0] tstamp;
        logic        valid;
    } t_entry;

    // Controls from the sequencer to every cell
    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

    localparam logic [7:0] CNT_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== src/bbc_cell.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache cell
// Holds one entry; rotates it to its neighbor or loads a broadcast write.
// ---------------------------------------------------------------------------
`default_nettype none

module bbc_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bbc_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_sel,
    input  wire bbc_pkg::t_entry   i_next,
    input  wire bbc_pkg::t_entry   i_wdata,
    output bbc_pkg::t_entry        o_entry
);

    bbc_pkg::t_entry r_entry;

    // entry storage: reset to zero, write wins over rotate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_ctl.wr && i_sel) begin
            r_entry <= i_wdata;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== src/bbc_ctrl.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache sequencer
// Scans the rotating row at its head cell, then writes back at most one entry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "block_buffer_cache_lru_macros.svh"

module bbc_ctrl #(
    parameter  int ENTRIES = 32,
    localparam int CW      = $clog2(ENTRIES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         i_command,
    input  wire logic [7:0]         i_device,
    input  wire logic [31:0]        i_block_number,
    input  wire logic [4:0]         i_buffer_index,
    input  wire logic [31:0]        i_tick,
    input  wire bbc_pkg::t_entry    i_head,
    output logic                    busy,
    output bbc_pkg::t_cell_ctl      o_ctl,
    output logic [CW-1:0]           o_pick,
    output bbc_pkg::t_entry         o_wdata,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [4:0]              o_buffer_index_out,
    output logic                    o_needs_fill,
    output logic [7:0]              o_ref_count_out
);

    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

    bbc_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_cnt;

    // latched request
    bbc_pkg::t_cmd    r_cmd;
    logic [7:0]       r_dev;
    logic [31:0]      r_blk;
    logic [4:0]       r_idx;
    logic [31:0]      r_tick;
    logic             r_inrange;

    // scan trackers
    logic             r_hit;
    logic [CW-1:0]    r_hidx;
    bbc_pkg::t_entry  r_hent;
    logic             r_free;
    logic [CW-1:0]    r_fidx;
    bbc_pkg::t_entry  r_fent;
    bbc_pkg::t_entry  r_aent;

    logic             w_accept;
    logic             w_match;
    logic             w_freec;
    logic             w_addr;

    bbc_pkg::t_status w_status;
    logic [4:0]       w_oidx;
    logic             w_fill;
    logic [7:0]       w_rcnt;
    logic             w_wr;
    logic [CW-1:0]    w_pick;
    bbc_pkg::t_entry  w_wdata;

    assign w_accept = start && (r_state == bbc_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bbc_pkg::S_IDLE: if (start) n_state = bbc_pkg::S_SCAN;
            bbc_pkg::S_SCAN: if (r_cnt == LAST) n_state = bbc_pkg::S_UPD;
            bbc_pkg::S_UPD:  n_state = bbc_pkg::S_IDLE;
            default:         n_state = bbc_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy        = (r_state != bbc_pkg::S_IDLE);
        o_ctl.shift = (r_state == bbc_pkg::S_SCAN);
        o_ctl.wr    = (r_state == bbc_pkg::S_UPD) && w_wr;
    end

    // state and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == bbc_pkg::S_SCAN) begin
                r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= bbc_pkg::t_cmd'(i_command);
            r_dev     <= i_device;
            r_blk     <= i_block_number;
            r_idx     <= i_buffer_index;
            r_tick    <= i_tick;
            r_inrange <= (32'(i_buffer_index) < ENTRIES);
        end
    end

    // head cell tests; r_cnt is the index of the entry at the head
    assign w_match = (i_head.dev == r_dev) && (i_head.blk == r_blk);
    assign w_freec = (i_head.cnt == 8'd0) && (!r_free || (i_head.tstamp < r_fent.tstamp));
    assign w_addr  = (32'(r_cnt) == 32'(r_idx));

    // tracker flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (w_accept) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_state == bbc_pkg::S_SCAN) begin
            if (!r_hit && w_match) r_hit <= 1'b1;
            if (w_freec) r_free <= 1'b1;
        end
    end

    // tracker payload: first match, oldest free, addressed entry
    always_ff @(posedge i_clk) begin
        if (r_state == bbc_pkg::S_SCAN) begin
            if (!r_hit && w_match) begin
                r_hidx <= r_cnt;
                r_hent <= i_head;
            end
            if (w_freec) begin
                r_fidx <= r_cnt;
                r_fent <= i_head;
            end
            if (w_addr) begin
                r_aent <= i_head;
            end
        end
    end

    // command result and write-back entry
    always_comb begin
        w_status = bbc_pkg::ST_DONE;
        w_oidx   = r_idx;
        w_fill   = 1'b0;
        w_rcnt   = 8'd0;
        w_wr     = 1'b0;
        w_pick   = CW'(r_idx);
        w_wdata  = r_aent;
        unique case (r_cmd) inside
            bbc_pkg::CMD_GET: begin
                if (r_hit) begin
                    w_pick        = r_hidx;
                    w_wdata       = r_hent;
                    w_wdata.cnt   = (r_hent.cnt == bbc_pkg::CNT_MAX) ? r_hent.cnt
                                                                     : r_hent.cnt + 8'd1;
                    w_wdata.valid = 1'b1;
                    w_oidx        = 5'(r_hidx);
                    w_fill        = !r_hent.valid;
                    w_rcnt        = w_wdata.cnt;
                    w_wr          = 1'b1;
                end else if (r_free) begin
                    w_pick         = r_fidx;
                    w_wdata.dev    = r_dev;
                    w_wdata.blk    = r_blk;
                    w_wdata.cnt    = 8'd1;
                    w_wdata.tstamp = r_fent.tstamp;
                    w_wdata.valid  = 1'b1;
                    w_status       = bbc_pkg::ST_MISS;
                    w_oidx         = 5'(r_fidx);
                    w_fill         = 1'b1;
                    w_rcnt         = 8'd1;
                    w_wr           = 1'b1;
                end else begin
                    w_status = bbc_pkg::ST_FULL;
                    w_oidx   = 5'd0;
                end
            end
            bbc_pkg::CMD_PIN: begin
                if (r_inrange) begin
                    w_wdata.cnt = (r_aent.cnt == bbc_pkg::CNT_MAX) ? r_aent.cnt
                                                                   : r_aent.cnt + 8'd1;
                    w_rcnt      = w_wdata.cnt;
                    w_wr        = 1'b1;
                end
            end
            bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
                if (r_inrange) begin
                    if (r_aent.cnt == 8'd0) begin
                        w_status = bbc_pkg::ST_UNDER;
                    end else begin
                        w_wdata.cnt = r_aent.cnt - 8'd1;
                        // release that drops the last reference stamps the time
                        if ((r_cmd == bbc_pkg::CMD_RELEASE) && (w_wdata.cnt == 8'd0)) begin
                            w_wdata.tstamp = r_tick;
                        end
                        w_rcnt = w_wdata.cnt;
                        w_wr   = 1'b1;
                    end
                end
            end
            default: begin
                w_wr = 1'b0;
            end
        endcase
    end

    assign o_pick  = w_pick;
    assign o_wdata = w_wdata;

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == bbc_pkg::S_UPD);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == bbc_pkg::S_UPD) begin
            o_status           <= w_status;
            o_buffer_index_out <= w_oidx;
            o_needs_fill       <= w_fill;
            o_ref_count_out    <= w_rcnt;
        end
    end

    // checks
    `BBC_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe held over two cycles")
    `BBC_ASSERT_NOW(a_strobe_after_upd, o_valid, $past(r_state) == bbc_pkg::S_UPD,
        "result strobe without a write-back cycle")
    `BBC_ASSERT_NEXT(a_accept_busy, w_accept, busy, "accepted item did not raise busy")
    `BBC_ASSERT_NOW(a_no_wr_while_shift, o_ctl.wr, !o_ctl.shift,
        "cell write during rotation")
    `BBC_ASSERT_NEXT(a_scan_wraps, (r_state == bbc_pkg::S_SCAN) && (r_cnt == LAST),
        (r_state == bbc_pkg::S_UPD) && (r_cnt == '0), "scan did not end with row aligned")

endmodule

`default_nettype wire

// ===== src/block_buffer_cache_lru.sv =====
// ---------------------------------------------------------------------------
// Block buffer cache directory with LRU replacement
// Row of entry cells rotating past one sequencer that scans and updates.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_command and its operands with start high while
//   busy is low; the item is taken at that edge. busy stays high until the
//   result has been produced.
//   Result channel: o_valid is high for exactly one cycle with o_status,
//   o_buffer_index_out, o_needs_fill and o_ref_count_out; the receiver must
//   take it then, it cannot stall the block.
//   Sequence: after acceptance the entry row rotates one cell per cycle past
//   the sequencer's head cell for a full turn, then the write-back state
//   writes at most one entry and the result strobe is registered from it;
//   a new command may be given in the cycle the strobe is high. Every
//   command, get or count change, takes the same time.
//   Reset: synchronous, active low; every entry clears to zero (tags zero,
//   counts zero, times zero, data not valid) at once, and the block is
//   ready as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lru #(
    parameter int ENTRIES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [1:0]  i_command,
    input  wire logic [7:0]  i_device,
    input  wire logic [31:0] i_block_number,
    input  wire logic [4:0]  i_buffer_index,
    input  wire logic [31:0] i_tick,
    output logic             busy,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [4:0]       o_buffer_index_out,
    output logic             o_needs_fill,
    output logic [7:0]       o_ref_count_out
);

    localparam int CW = $clog2(ENTRIES);

    bbc_pkg::t_entry    w_entry [ENTRIES];
    bbc_pkg::t_cell_ctl w_ctl;
    logic [CW-1:0]      w_pick;
    bbc_pkg::t_entry    w_wdata;

    // entry row: cell i takes from cell i+1, the last from cell 0
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        bbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_sel   (w_pick == CW'(i)),
            .i_next  (w_entry[(i + 1) % ENTRIES]),
            .i_wdata (w_wdata),
            .o_entry (w_entry[i])
        );
    end

    // sequencer watching the head cell
    bbc_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_command          (i_command),
        .i_device           (i_device),
        .i_block_number     (i_block_number),
        .i_buffer_index     (i_buffer_index),
        .i_tick             (i_tick),
        .i_head             (w_entry[0]),
        .busy               (busy),
        .o_ctl              (w_ctl),
        .o_pick             (w_pick),
        .o_wdata            (w_wdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_buffer_index_out (o_buffer_index_out),
        .o_needs_fill       (o_needs_fill),
        .o_ref_count_out    (o_ref_count_out)
    );

endmodule

`default_nettype wire
